// File: design/mmnc_pkg.sv
// Package for the motion mask neighbour count filter.
// Holds register indexes, field widths, reset values and the window bit count.
// No dependencies.
package mmnc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int FW_W       = 11;
    localparam int ROW_W      = 12;
    localparam int MIN_W      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_MIN_COUNT    = 2'd2
    } cfg_index_t;

    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [MIN_W-1:0] MIN_COUNT_RST    = 4'd2;

    // Number of set bits in the nine-pixel window.
    function automatic logic [MIN_W-1:0] window_ones(input logic [8:0] bits);
        logic [MIN_W-1:0] n;
        n = '0;
        for (int i = 0; i < 9; i++) begin
            n = n + MIN_W'(bits[i]);
        end
        return n;
    endfunction

endpackage

// File: design/mmnc_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
// One write and one read per cycle; read data holds while no read is issued.
// No dependencies.
module mmnc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/motion_mask_neighbour_count.sv
// Motion mask neighbour count filter: top level.
// Depends on mmnc_pkg and mmnc_ram.
//
// Usage:
// A binary motion mask enters on the s_ channel, one pixel per transaction,
// in raster order. For each interior pixel a transaction leaves on the m_
// channel with the centre column and row, a motion flag that is set when
// the 3x3 window around it holds at least min_count motion pixels, and a
// flag on the last interior pixel of the frame. Border pixels give nothing.
// The filter takes one pixel per clock while the receiver keeps up. The pixel
// that completes a window passes the read stage, where the line store is read,
// then the window update into the output register.
// The two rows above are held in one synchronous RAM of MAX_WIDTH entries
// of two bits, read and written back once per pixel.
// A stalled receiver holds the output register; the pixel behind it waits in
// the read stage and s_ready drops only while both are full.
// Reset clears the counters, the window, the pipeline and the registers to
// 640 x 480 with a threshold of two. The line store is not cleared; the first
// two rows after reset fill it before any result depends on it. The user must
// write geometry and threshold via the cfg_ port only while idle; not enforced.
module motion_mask_neighbour_count
    import mmnc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [CFG_IDX_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_motion_bit,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [$clog2(MAX_WIDTH)-1:0] m_centre_column,
    output logic [ROW_W-1:0]             m_centre_row,
    output logic                         m_motion_out,
    output logic                         m_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int UW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

    // Configuration registers.
    logic [FW_W-1:0]  frame_width_reg;
    logic [ROW_W-1:0] frame_height_reg;
    logic [MIN_W-1:0] min_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            min_count_reg    <= MIN_COUNT_RST;
        end else if (cfg_wen) begin
            case (cfg_addr)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[ROW_W-1:0];
                CFG_MIN_COUNT:    min_count_reg    <= cfg_wdata[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Geometry in use: width clamped to [3, MAX_WIDTH], height to at least 3.
    logic [UW-1:0]    fw_ext;
    logic [UW-1:0]    w_used;
    logic [UW-1:0]    w_last;
    logic [ROW_W-1:0] h_used;
    logic [ROW_W-1:0] h_last;

    always_comb begin
        fw_ext = UW'(frame_width_reg);
        if (fw_ext < UW'(3)) begin
            w_used = UW'(3);
        end else if (fw_ext > UW'(MAX_WIDTH)) begin
            w_used = UW'(MAX_WIDTH);
        end else begin
            w_used = fw_ext;
        end
        w_last = w_used - UW'(1);
        h_used = (frame_height_reg < ROW_W'(3)) ? ROW_W'(3) : frame_height_reg;
        h_last = h_used - ROW_W'(1);
    end

    // Pipeline control.
    logic s_accept;
    logic s1_valid_reg;
    logic s1_adv;
    logic m_valid_reg;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;

    // Position counters for the next pixel.
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (UW'(col_reg) >= w_last) begin
                col_next = '0;
                row_next = (row_reg >= h_last) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // Read stage: the line store entry of the accepted column is being read.
    logic             s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg <= s_motion_bit;
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
        end
    end

    // Line store: bit 0 is the pixel one row up, bit 1 the pixel two rows up.
    // Consecutive pixels always sit in different columns (the width is at
    // least three), so the write-back never meets the read of the same entry.
    logic [1:0] stored;
    logic [1:0] store_wdata;

    mmnc_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (store_wdata),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .rd_data (stored)
    );

    // Window update and decision.
    logic [2:0]       new_column;
    logic [8:0]       window_reg, window_next;
    logic [MIN_W-1:0] ones;
    logic             emit;

    always_comb begin
        store_wdata = {stored[0], s1_pix_reg};
        new_column  = {stored[1], stored[0], s1_pix_reg};
        window_next = s1_adv ? {window_reg[5:0], new_column} : window_reg;
        ones        = window_ones(window_next);
        emit        = (s1_col_reg >= CW'(2)) && (s1_row_reg >= ROW_W'(2)) &&
                      (UW'(s1_col_reg) < w_used) && (s1_row_reg < h_used);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            window_reg <= window_next;
            if (s1_adv) begin
                m_valid_reg <= emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    logic [CW-1:0]    m_col_reg;
    logic [ROW_W-1:0] m_row_reg;
    logic             m_motion_reg;
    logic             m_last_reg;

    always_ff @(posedge aclk) begin
        if (s1_adv && emit) begin
            m_col_reg    <= s1_col_reg - CW'(1);
            m_row_reg    <= s1_row_reg - ROW_W'(1);
            m_motion_reg <= (ones >= min_count_reg);
            m_last_reg   <= (UW'(s1_col_reg) == w_last) && (s1_row_reg == h_last);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_centre_column = m_col_reg;
    assign m_centre_row    = m_row_reg;
    assign m_motion_out    = m_motion_reg;
    assign m_frame_last    = m_last_reg;

endmodule

// File: design/mmnc_checker.sv
// Port-level checker for the motion mask neighbour count filter, with its bind.
// Depends on mmnc_pkg and attaches to motion_mask_neighbour_count.
module mmnc_checker
    import mmnc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [$clog2(MAX_WIDTH)-1:0] m_centre_column,
    input logic [ROW_W-1:0]             m_centre_row,
    input logic                         m_motion_out,
    input logic                         m_frame_last
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A result waiting to be taken keeps its content.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_centre_column) &&
        $stable(m_centre_row) && $stable(m_motion_out) && $stable(m_frame_last))
        else $error("stalled result changed");

    // Only interior pixels produce transactions.
    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_centre_column != 0) && (m_centre_row != 0))
        else $error("border pixel reported");

    // With the output register empty the input side is never stalled.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // A new result follows an accepted pixel that passed the read stage into the output register.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching input transaction");

endmodule

bind motion_mask_neighbour_count mmnc_checker #(.MAX_WIDTH(MAX_WIDTH)) u_mmnc_checker (.*);
